[design/strict_priority_multi_queue_scheduler_macros.svh]
// Assertion macros for the strict priority queue scheduler.
// Uses the top level clock i_clk and synchronous active-low reset i_rst_n.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_SCHEDULER_MACROS_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

[design/spq_pkg.sv]
// Shared types, sizes and codes of the strict priority queue scheduler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Sizing
    localparam int NUM_CLASSES = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    // Fixed port field widths
    localparam int QCLASS_W = 3;
    localparam int THREAD_W = 8;
    localparam int PCLASS_W = 2;
    localparam int ERR_W    = 3;

    // Derived widths
    localparam int CLASS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CLSCMP_W    = QCLASS_W + 1;

    // Request codes
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_PICK = 1'b1;

    // Timer class, eligible for pick only with timer ready
    localparam int CLASS_TIMER = 1;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_STATE = 3'd1,
        ERR_CLASS = 3'd2,
        ERR_FULL  = 3'd3,
        ERR_EMPTY = 3'd4
    } t_err;

    // One registered request word
    typedef struct packed {
        logic                valid;
        logic                req_type;
        logic [THREAD_W-1:0] thread_id;
        logic [QCLASS_W-1:0] queue_class;
        logic                thread_normal;
        logic                timer_ready;
    } t_item;

    // Access to the thread identifier store
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [ID_WIDTH-1:0] wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_store_req;

    // Result word, minus the identifier which comes from the store
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [CLASS_W-1:0] cls;
        t_err               err;
    } t_result;

endpackage

`default_nettype wire

[design/spq_store.sv]
// Thread identifier store: one flat memory holding all class queues.
// Depends on spq_pkg for sizes and the access struct.
`timescale 1ns / 1ps
`default_nettype none

module spq_store (
    input  wire logic                        i_clk,
    input  wire spq_pkg::t_store_req         i_req,
    output logic [spq_pkg::ID_WIDTH-1:0]     o_rd_data
);

    logic [spq_pkg::ID_WIDTH-1:0] mem [spq_pkg::STORE_DEPTH];
    logic [spq_pkg::ID_WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/spq_queue_ctrl.sv]
// Queue control: per-class head, tail and count, put checks, priority pick.
// Depends on spq_pkg; drives the spq_store access struct.
`timescale 1ns / 1ps
`default_nettype none

module spq_queue_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire spq_pkg::t_item      i_item,
    output spq_pkg::t_store_req      o_store,
    output spq_pkg::t_result         o_res
);

    logic [spq_pkg::PTR_W-1:0] r_head [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::PTR_W-1:0] r_tail [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::CNT_W-1:0] r_cnt  [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::PTR_W-1:0] n_head [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::PTR_W-1:0] n_tail [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::CNT_W-1:0] n_cnt  [spq_pkg::NUM_CLASSES];

    spq_pkg::t_result r_res;
    spq_pkg::t_result n_res;

    logic                        cls_ok;
    logic [spq_pkg::CLASS_W-1:0] put_cls;
    logic                        found;
    logic [spq_pkg::CLASS_W-1:0] sel_cls;

    // Pointer advance with wrap at the queue depth
    function automatic logic [spq_pkg::PTR_W-1:0] next_ptr(
        input logic [spq_pkg::PTR_W-1:0] ptr
    );
        if (ptr == spq_pkg::PTR_W'(spq_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + spq_pkg::PTR_W'(1);
    endfunction

    // Flat store address of a class slot
    function automatic logic [spq_pkg::STORE_AW-1:0] slot_addr(
        input logic [spq_pkg::CLASS_W-1:0] cls,
        input logic [spq_pkg::PTR_W-1:0]   ptr
    );
        return spq_pkg::STORE_AW'(cls) * spq_pkg::STORE_AW'(spq_pkg::QUEUE_DEPTH)
             + spq_pkg::STORE_AW'(ptr);
    endfunction

    assign cls_ok  = {1'b0, i_item.queue_class} < spq_pkg::CLSCMP_W'(spq_pkg::NUM_CLASSES);
    assign put_cls = spq_pkg::CLASS_W'(i_item.queue_class);

    // Priority encoder: lowest class with entries, timer gated by timer ready
    always_comb begin
        found   = 1'b0;
        sel_cls = '0;
        for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
            if (!found && (r_cnt[c] != '0)
                && !((c == spq_pkg::CLASS_TIMER) && !i_item.timer_ready)) begin
                found   = 1'b1;
                sel_cls = spq_pkg::CLASS_W'(c);
            end
        end
    end

    // Next state and result for the request word
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        o_store   = '0;
        n_res     = '0;
        n_res.err = spq_pkg::ERR_OK;
        if (i_item.valid) begin
            n_res.valid = 1'b1;
            if (i_item.req_type == spq_pkg::REQ_PUT) begin
                if (!i_item.thread_normal) begin
                    n_res.err = spq_pkg::ERR_STATE;
                end else if (!cls_ok) begin
                    n_res.err = spq_pkg::ERR_CLASS;
                end else if (r_cnt[put_cls] == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH)) begin
                    n_res.err = spq_pkg::ERR_FULL;
                end else begin
                    o_store.we      = 1'b1;
                    o_store.waddr   = slot_addr(put_cls, r_tail[put_cls]);
                    o_store.wdata   = spq_pkg::ID_WIDTH'(i_item.thread_id);
                    n_tail[put_cls] = next_ptr(r_tail[put_cls]);
                    n_cnt[put_cls]  = r_cnt[put_cls] + spq_pkg::CNT_W'(1);
                end
            end else begin
                if (found) begin
                    o_store.re      = 1'b1;
                    o_store.raddr   = slot_addr(sel_cls, r_head[sel_cls]);
                    n_head[sel_cls] = next_ptr(r_head[sel_cls]);
                    n_cnt[sel_cls]  = r_cnt[sel_cls] - spq_pkg::CNT_W'(1);
                    n_res.hit       = 1'b1;
                    n_res.cls       = sel_cls;
                end else begin
                    n_res.err = spq_pkg::ERR_EMPTY;
                end
            end
        end
    end

    // Queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    // Result register; strobe reset, rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= n_res.valid;
        end
        r_res.hit <= n_res.hit;
        r_res.cls <= n_res.cls;
        r_res.err <= n_res.err;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[design/strict_priority_multi_queue_scheduler.sv]
// Top level of the strict priority multi-queue scheduler: request register,
// queue control, identifier store and result ports. Depends on spq_pkg,
// spq_queue_ctrl, spq_store and the assertion macro header.
//
//  channel | handshake                | fields
//  --------+--------------------------+-----------------------------------------------------
//  request | start in, busy out       | req_type thread_id queue_class thread_normal timer_ready
//  result  | o_valid strobe, no stall | picked_valid picked_thread picked_class error_code
//
// One word is accepted every cycle while busy is low; its result strobes after
// the request register, then the result and store read register.
// busy is high during reset and until the ready flag is registered after release, low after that.
// Reset clears all head, tail and count registers; the store is not cleared.
// The receiver cannot stall: each result is present for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_priority_multi_queue_scheduler_macros.svh"

module strict_priority_multi_queue_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_req_type,
    input  wire logic [spq_pkg::THREAD_W-1:0]  i_thread_id,
    input  wire logic [spq_pkg::QCLASS_W-1:0]  i_queue_class,
    input  wire logic                          i_thread_normal,
    input  wire logic                          i_timer_ready,
    output logic                               o_valid,
    output logic                               o_picked_valid,
    output logic [spq_pkg::THREAD_W-1:0]       o_picked_thread,
    output logic [spq_pkg::PCLASS_W-1:0]       o_picked_class,
    output logic [spq_pkg::ERR_W-1:0]          o_error_code
);

    logic                         r_live;
    logic                         accept;
    spq_pkg::t_item               r_item;
    spq_pkg::t_store_req          store_req;
    spq_pkg::t_result             res;
    logic [spq_pkg::ID_WIDTH-1:0] rd_data;
    logic                         put_taken;
    logic                         no_pick;

    assign busy   = !r_live;
    assign accept = start && !busy;

    // Ready flag, set once reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= accept;
        end
        r_item.req_type      <= i_req_type;
        r_item.thread_id     <= i_thread_id;
        r_item.queue_class   <= i_queue_class;
        r_item.thread_normal <= i_thread_normal;
        r_item.timer_ready   <= i_timer_ready;
    end

    spq_queue_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .o_store (store_req),
        .o_res   (res)
    );

    spq_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // Result ports; identifier forced to zero when no thread was picked
    assign o_valid         = res.valid;
    assign o_picked_valid  = res.hit;
    assign o_picked_thread = res.hit ? spq_pkg::THREAD_W'(rd_data) : '0;
    assign o_picked_class  = spq_pkg::PCLASS_W'(res.cls);
    assign o_error_code    = res.err;

    // Terms for the checks below
    assign put_taken = accept && (i_req_type == spq_pkg::REQ_PUT);
    assign no_pick   = !o_picked_valid && (o_picked_thread == '0) && (o_picked_class == '0);

    // Every accepted word gives a result after the request and result registers
    `SPQ_ASSERT_NXT(a_result_follows, accept, ##1 o_valid)
    // A put never returns a thread
    `SPQ_ASSERT_NXT(a_put_no_pick, put_taken, ##1 !o_picked_valid)
    // An empty pick carries no thread and no class
    `SPQ_ASSERT_IMP(a_empty_clean, o_valid && (o_error_code == spq_pkg::ERR_EMPTY), no_pick)

endmodule

`default_nettype wire
